@@ design/chime_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chime package
// Register map, field widths and reset values shared by the chime tone
// generator, its result stream interface and its configuration port.
// ----------------------------------------------------------------------------
package chime_pkg;

  // Widths of the configuration registers and the stream fields.
  localparam int PERIOD_BITS   = 20;
  localparam int AMP_BITS      = 10;
  localparam int INTERVAL_BITS = 3;
  localparam int DAC_BITS      = 10;

  // Configuration port geometry.
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = PERIOD_BITS;

  // Widest values the module parameters may take; used for zero extension.
  localparam int MAX_TIMER_BITS = 32;
  localparam int MAX_LEVEL_BITS = 16;

  // Default module parameters.
  localparam int DEFAULT_TIMER_BITS = 20;
  localparam int DEFAULT_LEVEL_BITS = 10;

  // Register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] REG_HIGH_TONE_PERIOD = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LOW_TONE_PERIOD  = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_START_AMPLITUDE  = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DECAY_STEP       = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DECAY_INTERVAL   = 3'd4;

  // Register reset values.
  localparam logic [PERIOD_BITS-1:0]   RST_HIGH_TONE_PERIOD = 20'd75873;
  localparam logic [PERIOD_BITS-1:0]   RST_LOW_TONE_PERIOD  = 20'd95602;
  localparam logic [AMP_BITS-1:0]      RST_START_AMPLITUDE  = 10'd1023;
  localparam logic [AMP_BITS-1:0]      RST_DECAY_STEP       = 10'd10;
  localparam logic [INTERVAL_BITS-1:0] RST_DECAY_INTERVAL   = 3'd5;

  // The decay count saturates here.
  localparam logic [INTERVAL_BITS-1:0] DECAY_COUNT_MAX = 3'd7;

  // Button line is active low.
  localparam logic BUTTON_RELEASED = 1'b1;

  typedef struct packed {
    logic [PERIOD_BITS-1:0]   high_tone_period;
    logic [PERIOD_BITS-1:0]   low_tone_period;
    logic [AMP_BITS-1:0]      start_amplitude;
    logic [AMP_BITS-1:0]      decay_step;
    logic [INTERVAL_BITS-1:0] decay_interval;
  } chime_cfg_t;

endpackage

@@ design/chime_tick_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chime tick stream
// Valid/ready channel carrying one timer tick with the sampled button line.
// ----------------------------------------------------------------------------
interface chime_tick_if ();
  logic valid;
  logic ready;
  logic button_level;

  modport source (output valid, output button_level, input ready);
  modport sink   (input valid, input button_level, output ready);
endinterface

@@ design/chime_result_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chime result stream
// Valid/ready channel carrying the DAC level and the half-period flag.
// ----------------------------------------------------------------------------
interface chime_result_if import chime_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [DAC_BITS-1:0] dac_value;
  logic                half_period_end;

  modport source (output valid, output dac_value, output half_period_end, input ready);
  modport sink   (input valid, input dac_value, input half_period_end, output ready);
endinterface

@@ design/decaying_chime_tone_generator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decaying chime tone generator
// Square-wave chime whose amplitude decays every few half periods and is
// reloaded on each button press or release.
// ----------------------------------------------------------------------------
// Output: a result is registered and is valid in the cycle after its tick transaction.
// Throughput: one tick per cycle; the output register frees itself in the
// same cycle its result is taken, so the tick side stalls only on a stall
// of the result side.
// Reset: synchronous; clears the tone state, loads the register defaults
// and empties the output register.
module decaying_chime_tone_generator
  import chime_pkg::*;
#(
  parameter int TIMER_BITS = DEFAULT_TIMER_BITS,
  parameter int LEVEL_BITS = DEFAULT_LEVEL_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  chime_tick_if.sink                tick,
  chime_result_if.source            result,
  input  logic                      wr_en,
  input  logic [CFG_INDEX_BITS-1:0] wr_index,
  input  logic [CFG_DATA_BITS-1:0]  wr_data
);

  chime_cfg_t cfg;

  logic                     last_button;
  logic                     tone_select;
  logic [TIMER_BITS-1:0]    tick_timer;
  logic                     wave_phase;
  logic [LEVEL_BITS-1:0]    amplitude;
  logic [INTERVAL_BITS-1:0] decay_count;
  logic [LEVEL_BITS-1:0]    dac_level;

  logic                     last_button_next;
  logic                     tone_select_next;
  logic [TIMER_BITS-1:0]    tick_timer_next;
  logic                     wave_phase_next;
  logic [LEVEL_BITS-1:0]    amplitude_next;
  logic [INTERVAL_BITS-1:0] decay_count_next;
  logic [LEVEL_BITS-1:0]    dac_level_next;
  logic                     ended;

  logic                      out_valid;
  logic [DAC_BITS-1:0]       out_dac;
  logic                      out_end;

  logic                      tick_fire;
  logic                      edge_tick;
  logic [MAX_TIMER_BITS-1:0] period_wide;
  logic [TIMER_BITS-1:0]     period;
  logic [TIMER_BITS-1:0]     timer_inc;
  logic [MAX_LEVEL_BITS-1:0] amp_wide;
  logic [MAX_LEVEL_BITS-1:0] step_wide;
  logic [MAX_LEVEL_BITS-1:0] amp_dec_wide;
  logic [MAX_LEVEL_BITS-1:0] start_wide;
  logic [MAX_LEVEL_BITS-1:0] dac_wide;
  logic                      phase_flip;
  logic [INTERVAL_BITS-1:0]  count_after;

  // The result register frees itself in the cycle its result is taken.
  assign tick.ready = !out_valid || result.ready;
  assign tick_fire  = tick.valid && tick.ready;
  assign edge_tick  = tick.button_level != last_button;

  assign period_wide  = MAX_TIMER_BITS'(tone_select ? cfg.low_tone_period
                                                    : cfg.high_tone_period);
  assign period       = period_wide[TIMER_BITS-1:0];
  assign timer_inc    = tick_timer + 1'b1;
  assign amp_wide     = MAX_LEVEL_BITS'(amplitude);
  assign step_wide    = MAX_LEVEL_BITS'(cfg.decay_step);
  assign amp_dec_wide = amp_wide - step_wide;
  assign start_wide   = MAX_LEVEL_BITS'(cfg.start_amplitude);
  assign phase_flip   = !wave_phase;

  always_comb begin
    last_button_next = tick.button_level;
    tone_select_next = tone_select;
    tick_timer_next  = tick_timer;
    wave_phase_next  = wave_phase;
    amplitude_next   = amplitude;
    decay_count_next = decay_count;
    dac_level_next   = dac_level;
    ended            = 1'b0;
    count_after      = decay_count;
    if (edge_tick) begin
      tone_select_next = tick.button_level;
      amplitude_next   = start_wide[LEVEL_BITS-1:0];
      decay_count_next = '0;
      tick_timer_next  = '0;
    end else if (timer_inc == period) begin
      ended           = 1'b1;
      tick_timer_next = '0;
      wave_phase_next = phase_flip;
      dac_level_next  = phase_flip ? amplitude : '0;
      if (decay_count == cfg.decay_interval && amp_wide > step_wide) begin
        amplitude_next = amp_dec_wide[LEVEL_BITS-1:0];
        count_after    = '0;
      end else if (amplitude != '0 && amp_wide < step_wide) begin
        amplitude_next = '0;
      end
      decay_count_next = (count_after == DECAY_COUNT_MAX) ? count_after
                                                          : count_after + 1'b1;
    end else begin
      tick_timer_next = timer_inc;
    end
  end

  assign dac_wide = MAX_LEVEL_BITS'(dac_level_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.high_tone_period <= RST_HIGH_TONE_PERIOD;
      cfg.low_tone_period  <= RST_LOW_TONE_PERIOD;
      cfg.start_amplitude  <= RST_START_AMPLITUDE;
      cfg.decay_step       <= RST_DECAY_STEP;
      cfg.decay_interval   <= RST_DECAY_INTERVAL;
    end else if (wr_en) begin
      case (wr_index)
        REG_HIGH_TONE_PERIOD: cfg.high_tone_period <= wr_data;
        REG_LOW_TONE_PERIOD:  cfg.low_tone_period  <= wr_data;
        REG_START_AMPLITUDE:  cfg.start_amplitude  <= wr_data[AMP_BITS-1:0];
        REG_DECAY_STEP:       cfg.decay_step       <= wr_data[AMP_BITS-1:0];
        REG_DECAY_INTERVAL:   cfg.decay_interval   <= wr_data[INTERVAL_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_button <= BUTTON_RELEASED;
      tone_select <= 1'b0;
      tick_timer  <= '0;
      wave_phase  <= 1'b0;
      amplitude   <= '0;
      decay_count <= '0;
      dac_level   <= '0;
    end else if (tick_fire) begin
      last_button <= last_button_next;
      tone_select <= tone_select_next;
      tick_timer  <= tick_timer_next;
      wave_phase  <= wave_phase_next;
      amplitude   <= amplitude_next;
      decay_count <= decay_count_next;
      dac_level   <= dac_level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (tick_fire) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_fire) begin
      out_dac <= dac_wide[DAC_BITS-1:0];
      out_end <= ended;
    end
  end

  assign result.valid           = out_valid;
  assign result.dac_value       = out_dac;
  assign result.half_period_end = out_end;

  // A button edge never ends a half period.
  a_edge_no_end: assert property (@(posedge clk) disable iff (rst)
    (tick_fire && edge_tick) |=> !out_end)
    else $error("half period ended on a button edge");

  // Between edges the amplitude only decays.
  a_amp_decays: assert property (@(posedge clk) disable iff (rst)
    (tick_fire && !edge_tick) |=> (amplitude <= $past(amplitude)))
    else $error("amplitude grew without a button edge");

  // The DAC only carries a level on the high phase.
  a_dac_phase: assert property (@(posedge clk) disable iff (rst)
    (dac_level != '0) |-> wave_phase)
    else $error("DAC level nonzero on the low phase");

  // A result appears only after a tick transaction.
  a_valid_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(tick_fire))
    else $error("result valid without a tick transaction");

endmodule
